[rtl/gif_lzw_compressor_unit_assert.svh]
// Assertion helpers for the LZW compressor checker.
`ifndef GIF_LZW_COMPRESSOR_UNIT_ASSERT_SVH
`define GIF_LZW_COMPRESSOR_UNIT_ASSERT_SVH

// Checked only outside reset
`define GLZW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define GLZW_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/glzw_pkg.sv]
`timescale 1ns / 1ps
package glzw_pkg;

	localparam int unsigned MAX_CODE_BITS = 12;
	localparam int unsigned KEY_W         = 20;
	localparam int unsigned ACC_W         = 19;  // up to 7 pending bits plus a 12-bit code
	localparam int unsigned CNT_W         = 5;
	localparam int unsigned HASH_SHIFT    = 19;
	localparam int unsigned HASH_BITS     = 32 - HASH_SHIFT;

	localparam logic [31:0] HASH_MULT  = 32'd2654435761;
	localparam logic [11:0] CODE_LIMIT = 12'd4095;
	localparam logic [3:0]  MCS_MIN    = 4'd2;
	localparam logic [3:0]  MCS_MAX    = 4'd8;
	localparam logic [3:0]  MCS_RESET  = 4'd8;

	// One dictionary slot
	typedef struct packed {
		logic                   valid;
		logic [KEY_W-1:0]       key;
		logic [MAX_CODE_BITS-1:0] code;
	} entry_t;

	// Write request towards the table
	typedef struct packed {
		logic   en;
		entry_t data;
	} tbl_wr_t;

	// Multiplicative hash, low 32 bits of the product
	function automatic logic [31:0] hash_mul(input logic [KEY_W-1:0] key);
		logic [KEY_W+31:0] p;
		p = {32'd0, key} * {{KEY_W{1'b0}}, HASH_MULT};
		return p[31:0];
	endfunction

	// Clamp the minimum code size to 2..8
	function automatic logic [3:0] sat_mcs(input logic [3:0] m);
		logic [3:0] r;
		r = m;
		if (m < MCS_MIN) r = MCS_MIN;
		if (m > MCS_MAX) r = MCS_MAX;
		return r;
	endfunction

endpackage

[rtl/gif_lzw_compressor_unit.sv]
`timescale 1ns / 1ps
// GIF-style variable-width LZW compressor.
// Input channel (in_valid/in_ready): one palette index per word, with
// first_of_frame and last_of_frame marks. Output channel (out_valid/out_ready):
// one packed byte per word, LSB-first code packing; last_of_run marks the final
// byte caused by an input word and frame_done the final byte of a frame.
// cfg_we/cfg_data write the minimum code size, sampled at each frame start.
// One word is in flight at a time; in_ready is high only when idle.
// Steps per word: accept, hash, probe the table's registered read port, emit
// a code and pack its bytes, insert a new entry, check for the end of the
// frame and hand over the last byte. Each frame start and each dictionary
// reset (next code at 4095) sweeps every slot of the table.
// Reset empties the output register, closes any open frame and sets the code
// size to 8; the table is swept at the next frame start.
// When the receiver stalls, the sequencer holds at its next byte until the
// output register frees; nothing is dropped.
module gif_lzw_compressor_unit #(
	parameter int unsigned HASH_SLOTS = 8192
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel_index,
	input  logic       first_of_frame,
	input  logic       last_of_frame,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] packed_byte,
	output logic       last_of_run,
	output logic       frame_done
);

	localparam int unsigned AW = $clog2(HASH_SLOTS);
	localparam int unsigned HB = glzw_pkg::HASH_BITS;
	localparam int unsigned SW = ((AW > HB) ? AW : HB) + 1;
	localparam int unsigned CW = glzw_pkg::MAX_CODE_BITS;
	localparam int unsigned AC = glzw_pkg::ACC_W;
	localparam int unsigned NC = glzw_pkg::CNT_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(HASH_SLOTS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_ADDR, S_WAIT, S_CHK, S_PACK, S_GROW,
		S_SWEEP, S_LAST, S_END, S_FLUSH, S_DONE
	} state_t;

	state_t          state_q, ret_q;
	logic [3:0]      cfg_mcs_q, mcs_q, cw_q;
	logic            in_frame_q, last_q;
	logic [7:0]      pix_q;
	logic [CW-1:0]   prefix_q, next_code_q;
	logic [AC-1:0]   acc_q;
	logic [NC-1:0]   cnt_q;
	logic [31:0]     prod_q;
	logic [AW-1:0]   h_q, sweep_q;
	logic [7:0]      hold_q;
	logic            hold_v_q;
	logic [7:0]      out_q;
	logic            out_last_q, out_done_q, out_v_q;

	glzw_pkg::entry_t  rd_data;
	glzw_pkg::tbl_wr_t tbl_wr;
	logic [AW-1:0]     wr_addr;

	logic [3:0]    start_mcs, cw_new, emit_w;
	logic [CW-1:0] clear_code, emit_code, masked;
	logic [12:0]   wmask;
	logic [AC-1:0] acc_base, acc_emit;
	logic [NC-1:0] cnt_base, cnt_emit;
	logic [7:0]    start_pix;
	logic [SW-1:0] hv_w, hv_r;
	logic [glzw_pkg::KEY_W-1:0] key;
	logic          can_push, out_load, at_limit, is_start;

	// Frame start decode
	assign start_mcs = glzw_pkg::sat_mcs(cfg_mcs_q);
	assign start_pix = pixel_index & 8'((9'd1 << start_mcs) - 9'd1);
	assign is_start  = first_of_frame || !in_frame_q;
	assign clear_code = CW'(1) << mcs_q;
	assign key       = {prefix_q, pix_q};

	// Width growth and code limit
	assign cw_new = ((13'(next_code_q) >= (13'd1 << cw_q)) && (cw_q < 4'(CW)))
		? cw_q + 4'd1 : cw_q;
	assign at_limit = next_code_q >= glzw_pkg::CODE_LIMIT;

	// Code selection for the shared packing shifter
	always_comb begin
		acc_base  = acc_q;
		cnt_base  = cnt_q;
		emit_code = prefix_q;
		emit_w    = cw_q;
		case (state_q)
			S_IDLE: begin
				acc_base  = '0;
				cnt_base  = '0;
				emit_code = CW'(1) << start_mcs;
				emit_w    = start_mcs + 4'd1;
			end
			S_GROW: begin
				emit_code = clear_code;
				emit_w    = cw_new;
			end
			S_END: emit_code = clear_code + CW'(1);
			default: ;
		endcase
	end

	assign wmask    = (13'd1 << emit_w) - 13'd1;
	assign masked   = emit_code & wmask[CW-1:0];
	assign acc_emit = acc_base | (AC'(masked) << cnt_base);
	assign cnt_emit = cnt_base + NC'(emit_w);

	// Hash reduction: the shifted hash is below twice the slot count
	assign hv_w = SW'(prod_q[31:glzw_pkg::HASH_SHIFT]);
	assign hv_r = (hv_w >= SW'(HASH_SLOTS)) ? hv_w - SW'(HASH_SLOTS) : hv_w;

	// Table writes: insertion or clearing sweep
	always_comb begin
		tbl_wr.en         = 1'b0;
		tbl_wr.data.valid = 1'b0;
		tbl_wr.data.key   = key;
		tbl_wr.data.code  = next_code_q;
		wr_addr           = h_q;
		if (state_q == S_SWEEP) begin
			tbl_wr.en = 1'b1;
			wr_addr   = sweep_q;
		end else if (state_q == S_GROW && !at_limit) begin
			tbl_wr.en         = 1'b1;
			tbl_wr.data.valid = 1'b1;
		end
	end

	glzw_table #(.HASH_SLOTS(HASH_SLOTS)) u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.wr_addr (wr_addr),
		.rd_addr (h_q),
		.rd_data (rd_data)
	);

	assign can_push = !out_v_q || out_ready;

	// Held byte moves into the output register this cycle
	assign out_load = can_push && hold_v_q
		&& ((state_q == S_PACK && cnt_q >= NC'(8))
		|| (state_q == S_FLUSH && cnt_q != '0) || state_q == S_DONE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cfg_mcs_q   <= glzw_pkg::MCS_RESET;
			mcs_q       <= glzw_pkg::MCS_RESET;
			cw_q        <= '0;
			in_frame_q  <= 1'b0;
			last_q      <= 1'b0;
			pix_q       <= '0;
			prefix_q    <= '0;
			next_code_q <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			prod_q      <= '0;
			hold_q      <= '0;
			hold_v_q    <= 1'b0;
			out_q       <= '0;
			out_last_q  <= 1'b0;
			out_done_q  <= 1'b0;
			out_v_q     <= 1'b0;
			sweep_q     <= '0;
			h_q         <= '0;
		end else begin
			if (cfg_we) begin
				cfg_mcs_q <= cfg_data;
			end
			if (out_v_q && out_ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= last_of_frame;
						if (is_start) begin
							mcs_q       <= start_mcs;
							cw_q        <= start_mcs + 4'd1;
							next_code_q <= (CW'(1) << start_mcs) + CW'(2);
							acc_q       <= acc_emit;
							cnt_q       <= cnt_emit;
							prefix_q    <= CW'(start_pix);
							in_frame_q  <= 1'b1;
							sweep_q     <= '0;
							ret_q       <= S_SWEEP;
							state_q     <= S_PACK;
						end else begin
							pix_q   <= pixel_index & 8'((9'd1 << mcs_q) - 9'd1);
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					prod_q  <= glzw_pkg::hash_mul(key);
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					h_q     <= hv_r[AW-1:0];
					state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_CHK;
				S_CHK: begin
					if (!rd_data.valid) begin
						acc_q   <= acc_emit;
						cnt_q   <= cnt_emit;
						ret_q   <= S_GROW;
						state_q <= S_PACK;
					end else if (rd_data.key == key) begin
						prefix_q <= rd_data.code;
						state_q  <= S_LAST;
					end else begin
						h_q     <= (h_q == LAST_SLOT) ? '0 : h_q + AW'(1);
						state_q <= S_WAIT;
					end
				end
				S_GROW: begin
					prefix_q <= CW'(pix_q);
					if (at_limit) begin
						// clear code at the grown width, then dictionary reset
						acc_q       <= acc_emit;
						cnt_q       <= cnt_emit;
						cw_q        <= mcs_q + 4'd1;
						next_code_q <= (CW'(1) << mcs_q) + CW'(2);
						sweep_q     <= '0;
						ret_q       <= S_SWEEP;
						state_q     <= S_PACK;
					end else begin
						cw_q        <= cw_new;
						next_code_q <= next_code_q + CW'(1);
						state_q     <= S_LAST;
					end
				end
				S_SWEEP: begin
					if (sweep_q == LAST_SLOT) begin
						state_q <= S_LAST;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				S_LAST: begin
					if (last_q) begin
						acc_q   <= acc_emit;
						cnt_q   <= cnt_emit;
						ret_q   <= S_END;
						state_q <= S_PACK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_END: begin
					acc_q   <= acc_emit;
					cnt_q   <= cnt_emit;
					ret_q   <= S_FLUSH;
					state_q <= S_PACK;
				end
				S_PACK: begin
					// one byte per cycle unless the output register is stalled; previous held byte goes out first
					if (cnt_q >= NC'(8)) begin
						if (!hold_v_q || can_push) begin
							if (hold_v_q) begin
								out_q      <= hold_q;
								out_last_q <= 1'b0;
								out_done_q <= 1'b0;
								out_v_q    <= 1'b1;
							end
							hold_q   <= acc_q[7:0];
							hold_v_q <= 1'b1;
							acc_q    <= acc_q >> 8;
							cnt_q    <= cnt_q - NC'(8);
						end
					end else begin
						state_q <= ret_q;
					end
				end
				S_FLUSH: begin
					if (cnt_q == '0 || !hold_v_q || can_push) begin
						if (cnt_q != '0) begin
							if (hold_v_q) begin
								out_q      <= hold_q;
								out_last_q <= 1'b0;
								out_done_q <= 1'b0;
								out_v_q    <= 1'b1;
							end
							hold_q   <= acc_q[7:0];
							hold_v_q <= 1'b1;
						end
						acc_q      <= '0;
						cnt_q      <= '0;
						in_frame_q <= 1'b0;
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (!hold_v_q) begin
						state_q <= S_IDLE;
					end else if (can_push) begin
						out_q      <= hold_q;
						out_last_q <= 1'b1;
						out_done_q <= last_q;
						out_v_q    <= 1'b1;
						hold_v_q   <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_v_q;
	assign packed_byte = out_q;
	assign last_of_run = out_last_q;
	assign frame_done  = out_done_q;

endmodule

[rtl/glzw_table.sv]
`timescale 1ns / 1ps
// Hash table memory: one write port, one registered read port.
module glzw_table #(
	parameter int unsigned HASH_SLOTS = 8192,
	localparam int unsigned AW = $clog2(HASH_SLOTS)
) (
	input  logic              clk,
	input  glzw_pkg::tbl_wr_t wr,
	input  logic [AW-1:0]     wr_addr,
	input  logic [AW-1:0]     rd_addr,
	output glzw_pkg::entry_t  rd_data
);

	glzw_pkg::entry_t mem [HASH_SLOTS];
	glzw_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

[rtl/glzw_checker.sv]
`timescale 1ns / 1ps
`include "gif_lzw_compressor_unit_assert.svh"
// Port-level checks on the compressor.
module glzw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] packed_byte,
	input logic       last_of_run,
	input logic       frame_done
);

	// a stalled byte holds
	`GLZW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(packed_byte), "byte changed while stalled")
	// one word at a time
	`GLZW_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "accepted a second word")
	// end of frame closes the run
	`GLZW_ASSERT(a_done_run, out_valid && frame_done |-> last_of_run, "frame end without run end")
	// nothing shown once reset has been seen
	`GLZW_ASSERT_ANY(a_rst_quiet, !arst_n |=> !out_valid, "output valid after reset")

endmodule

bind gif_lzw_compressor_unit glzw_checker u_glzw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.packed_byte (packed_byte),
	.last_of_run (last_of_run),
	.frame_done  (frame_done)
);

[verif/tb_gif_lzw_compressor_unit.sv]
`timescale 1ns / 1ps
module tb_gif_lzw_compressor_unit;

	localparam int unsigned SLOTS     = 8192;
	localparam int unsigned WDOG_MAX  = 40000;
	localparam int unsigned CFG_INDEX = 0;

	typedef struct {
		logic [7:0] b;
		logic       run_end;
		logic       frm_end;
	} lzw_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] pixel_index = '0;
	logic       first_of_frame = 1'b0;
	logic       last_of_frame = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] packed_byte;
	logic       last_of_run;
	logic       frame_done;

	// Encoder shadow state
	bit          dict_used [SLOTS];
	int unsigned dict_key  [SLOTS];
	int unsigned dict_code [SLOTS];
	int unsigned prefix_code, next_free_code, cur_width, bit_buf, bit_cnt;
	int unsigned code_size_reg, frame_code_size;
	bit          frame_open;
	lzw_byte_t   byte_stream_q [$];
	lzw_byte_t   step_bytes [$];

	int  errors = 0;
	int  quiet_cycles = 0;
	bit  idle_on = 1'b1;

	gif_lzw_compressor_unit #(.HASH_SLOTS(SLOTS)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .pixel_index(pixel_index),
		.first_of_frame(first_of_frame), .last_of_frame(last_of_frame),
		.out_valid(out_valid), .out_ready(out_ready), .packed_byte(packed_byte),
		.last_of_run(last_of_run), .frame_done(frame_done)
	);

	always #1 clk = ~clk;

	// Pack a code LSB first, appending finished bytes
	function automatic void pack_code(int unsigned code, int unsigned w);
		lzw_byte_t   e;
		int unsigned acc, tot;
		acc = bit_buf | ((code & ((32'd1 << w) - 1)) << bit_cnt);
		tot = bit_cnt + w;
		while (tot >= 8) begin
			e.b = acc[7:0];
			e.run_end = 1'b0;
			e.frm_end = 1'b0;
			step_bytes = {step_bytes, e};
			acc = acc >> 8;
			tot -= 8;
		end
		bit_buf = acc & 8'hff;
		bit_cnt = tot;
	endfunction

	function automatic void clear_dict();
		foreach (dict_used[i]) dict_used[i] = 1'b0;
		cur_width = frame_code_size + 1;
		next_free_code = (32'd1 << frame_code_size) + 2;
	endfunction

	// Work out the bytes caused by one pixel word
	function automatic void encode_pixel(logic [7:0] pix, logic first, logic last);
		int unsigned k, key, h, n;
		logic [31:0] prod;
		bit          free_slot, hit;
		lzw_byte_t   e;
		step_bytes.delete();
		if (first || !frame_open) begin
			frame_code_size = code_size_reg < 2 ? 2 : (code_size_reg > 8 ? 8 : code_size_reg);
			clear_dict();
			bit_buf = 0;
			bit_cnt = 0;
			pack_code(32'd1 << frame_code_size, cur_width);
			prefix_code = pix & ((32'd1 << frame_code_size) - 1);
			frame_open = 1'b1;
		end else begin
			k = pix & ((32'd1 << frame_code_size) - 1);
			key = ((prefix_code & 12'hfff) << 8) | k;
			prod = key * glzw_pkg::HASH_MULT;
			h = (prod >> glzw_pkg::HASH_SHIFT) % SLOTS;
			free_slot = 1'b0;
			hit = 1'b0;
			for (n = 0; n < SLOTS; n++) begin
				if (!dict_used[h]) begin
					free_slot = 1'b1;
					break;
				end
				if (dict_key[h] == key) begin
					hit = 1'b1;
					break;
				end
				h = (h + 1) % SLOTS;
			end
			if (hit) begin
				prefix_code = dict_code[h];
			end else begin
				pack_code(prefix_code, cur_width);
				if (next_free_code >= (32'd1 << cur_width)
				    && cur_width < glzw_pkg::MAX_CODE_BITS)
					cur_width++;
				if (next_free_code >= glzw_pkg::CODE_LIMIT) begin
					pack_code(32'd1 << frame_code_size, cur_width);
					clear_dict();
				end else if (free_slot) begin
					dict_used[h] = 1'b1;
					dict_key[h] = key;
					dict_code[h] = next_free_code;
					next_free_code++;
				end
				prefix_code = k;
			end
		end
		if (last) begin
			pack_code(prefix_code, cur_width);
			pack_code((32'd1 << frame_code_size) + 1, cur_width);
			if (bit_cnt > 0) begin
				e.b = bit_buf[7:0];
				e.run_end = 1'b0;
				e.frm_end = 1'b0;
				step_bytes = {step_bytes, e};
			end
			bit_buf = 0;
			bit_cnt = 0;
			frame_open = 1'b0;
		end
		if (step_bytes.size() > 0) begin
			step_bytes[step_bytes.size()-1].run_end = 1'b1;
			step_bytes[step_bytes.size()-1].frm_end = last;
		end
		byte_stream_q = {byte_stream_q, step_bytes};
	endfunction

	// Send one pixel word, with an optional idle burst first
	task automatic send_pixel(logic [7:0] pix, logic first, logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_index <= pix;
		first_of_frame <= first;
		last_of_frame <= last;
		do @(posedge clk); while (!in_ready);
		encode_pixel(pix, first, last);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (byte_stream_q.size() > 0) @(negedge clk);
	endtask

	// Write the code size once the block has gone quiet
	task automatic write_code_size(logic [3:0] v);
		drain();
		while (!in_ready) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (CFG_INDEX == 0) code_size_reg = v;
	endtask

	task automatic send_frame(int len, int alphabet);
		for (int i = 0; i < len; i++)
			send_pixel(8'($urandom_range(0, alphabet - 1)), i == 0, i == len - 1);
	endtask

	task automatic test_directed();
		send_pixel(8'd0, 1'b1, 1'b0);
		for (int i = 0; i < 6; i++) send_pixel(i[0] ? 8'd255 : 8'd0, 1'b0, 1'b0);
		send_pixel(8'd255, 1'b0, 1'b1);
		// one-pixel frame
		send_pixel(8'd170, 1'b1, 1'b1);
		// word with no open frame starts one
		send_pixel(8'd85, 1'b0, 1'b0);
		send_pixel(8'd85, 1'b0, 1'b0);
		send_pixel(8'd85, 1'b0, 1'b0);
		// restart drops the open frame
		send_pixel(8'd1, 1'b1, 1'b0);
		send_pixel(8'd2, 1'b0, 1'b0);
		send_pixel(8'd1, 1'b0, 1'b0);
		send_pixel(8'd2, 1'b0, 1'b1);
	endtask

	task automatic test_code_sizes();
		logic [3:0] sizes [6] = '{4'd2, 4'd0, 4'd15, 4'd5, 4'd9, 4'd8};
		foreach (sizes[i]) begin
			write_code_size(sizes[i]);
			// pixels wider than the code size get trimmed
			send_frame(8, 256);
			send_frame(8, 4);
		end
	endtask

	task automatic test_random();
		int len, alpha;
		for (int f = 0; f < 10; f++) begin
			if (f == 6) drain();
			len = $urandom_range(1, 16);
			alpha = $urandom_range(0, 1) ? 256 : $urandom_range(2, 6);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_pixel(8'($urandom_range(0, 255)), 1'b1, 1'b0);
				send_pixel(8'($urandom_range(0, alpha - 1)), i == 0, i == len - 1);
			end
		end
	endtask

	// Closing frame with no idling on either side
	task automatic test_steady_stream();
		write_code_size(4'd8);
		idle_on = 1'b0;
		send_frame(20, 256);
	endtask

	// Result checker
	always @(posedge clk) begin
		lzw_byte_t e;
		if (arst_n && out_valid && out_ready) begin
			if (byte_stream_q.size() == 0) begin
				$display("%0t: unexpected byte %h", $realtime, packed_byte);
				errors++;
			end else begin
				e = byte_stream_q.pop_front();
				if (packed_byte !== e.b || last_of_run !== e.run_end
				    || frame_done !== e.frm_end) begin
					$display("%0t: expected %h/%b/%b actual %h/%b/%b", $realtime,
					         e.b, e.run_end, e.frm_end,
					         packed_byte, last_of_run, frame_done);
					errors++;
				end
			end
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WDOG_MAX) begin
			$display("FAIL gif_lzw_compressor_unit");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver stalls
	initial begin
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	initial begin
		code_size_reg = glzw_pkg::MCS_RESET;
		frame_code_size = glzw_pkg::MCS_RESET;
		frame_open = 1'b0;
		prefix_code = 0;
		next_free_code = 0;
		cur_width = 0;
		bit_buf = 0;
		bit_cnt = 0;
		foreach (dict_used[i]) dict_used[i] = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_code_sizes();
		write_code_size(4'd8);
		test_random();
		test_steady_stream();
		drain();
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("PASS gif_lzw_compressor_unit");
		else
			$display("FAIL gif_lzw_compressor_unit");
		$finish;
	end

endmodule
